/* hw/rtl/lnce_pkg.sv */
// lnce_pkg: shared types and constants of the line numbering and caret escape filter.
// Holds the channel payload structs, the digit cell control struct, the state
// encoding and the character codes. Depends on nothing.
package lnce_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // control shared by every digit cell of the counter chain
  typedef struct packed {
    logic rotate;
    logic incr;
  } cell_ctl_t;

  // up to four rendered bytes of one input byte, not counting a line number
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } glyph_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_DIG  = 5'b00100,
    S_TAB  = 5'b01000,
    S_GLY  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    REG_NUMBER_ALL       = 3'd0,
    REG_NUMBER_NONBLANK  = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } reg_index_t;

  localparam int unsigned FIELD_WIDTH = 6;

  localparam logic [3:0] DIGIT_ZERO = 4'd0;
  localparam logic [3:0] DIGIT_ONE  = 4'd1;
  localparam logic [3:0] DIGIT_NINE = 4'd9;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_M        = 8'h4D;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CTRL_OFFSET = 8'h40;
  localparam logic [6:0] CTRL_LIMIT  = 7'h20;
  localparam logic [6:0] CH_DEL      = 7'h7F;

endpackage

/* hw/rtl/line_numbering_caret_escape_filter_top.sv */
// line_numbering_caret_escape_filter_top: byte stream display filter with line
// numbers, blank squeezing, end marks and caret notation.
// Depends on lnce_pkg, lnce_cell and lnce_glyph.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one raw byte and a new_file
//   mark; the output channel out_valid/out_stall/out_data carries display bytes,
//   last_of_run marking the final byte caused by one input byte. A squeezed blank
//   line gives no output at all.
//   An unnumbered byte's first output byte is registered and appears in the
//   cycle after acceptance; plain text flows at one byte per cycle while the
//   receiver does not stall. Further rendered bytes follow from S_GLY. A numbered
//   line goes through an accept step that emits nothing, the pad spaces (0 to 5),
//   one rotation of the digit chain (most significant first, leading zeros
//   silent) and the tab, which increments the chain unless it is saturated.
//   The APB port (psel..pready) holds six one-bit control registers at 4*i; write
//   them only while the block is idle. pready is always high.
//   Reset clears all controls, sets the line counter to one and the block to the
//   start of a line. When the receiver stalls, the output byte holds and the
//   input is stalled until the output register frees.
module line_numbering_caret_escape_filter_top #(
  parameter int unsigned NUMBER_DIGITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lnce_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lnce_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lnce_pkg::*;

  localparam int unsigned KW = $clog2(NUMBER_DIGITS);
  localparam logic [KW-1:0] KLAST = KW'(NUMBER_DIGITS - 1);

  // configuration
  logic number_all_r, number_nonblank_r, squeeze_blank_r;
  logic show_ends_r, show_tabs_r, show_nonprinting_r;
  logic cfg_wr;
  reg_index_t cfg_idx;

  // control
  state_t     state_r, state_nxt;
  logic       als_r, als_nxt;
  logic       ibr_r, ibr_nxt;
  glyph_t     gly_r, gly_nxt, gly_in;
  logic [1:0] gidx_r, gidx_nxt;
  logic [2:0] pad_r, pad_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic       lead_r, lead_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic       slot_free, in_acc;
  logic       emit, emit_last;
  logic [7:0] emit_byte;
  logic       als_eff, ibr_eff, is_nl, drop, num;
  logic [2:0] cnt6, pad_now;
  logic [3:0] top_digit;
  logic       show_digit, full;

  // digit chain
  cell_ctl_t  ctl;
  logic [NUMBER_DIGITS-1:0][3:0] digits;
  logic [NUMBER_DIGITS-1:0]      nines_out, nz_out;

  genvar gi;
  generate
    for (gi = 0; gi < NUMBER_DIGITS; gi++) begin : g_cell
      lnce_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .reset_digit ((gi == 0) ? DIGIT_ONE : DIGIT_ZERO),
        .rot_in      ((gi == 0) ? digits[NUMBER_DIGITS-1] : digits[(gi == 0) ? 0 : gi-1]),
        .nines_in    ((gi == 0) ? 1'b1 : nines_out[(gi == 0) ? 0 : gi-1]),
        .nz_in       ((gi == NUMBER_DIGITS-1) ? 1'b0
                      : nz_out[(gi == NUMBER_DIGITS-1) ? gi : gi+1]),
        .digit       (digits[gi]),
        .nines_out   (nines_out[gi]),
        .nz_out      (nz_out[gi])
      );
    end
  endgenerate

  assign full      = nines_out[NUMBER_DIGITS-1];
  assign top_digit = digits[NUMBER_DIGITS-1];

  // spaces ahead of the digits: field width minus significant digit count
  always_comb begin
    cnt6 = 3'd1;
    for (int i = 1; i < 6; i++) begin
      cnt6 = cnt6 + {2'b00, nz_out[i]};
    end
    pad_now = nz_out[5] ? 3'd0 : 3'(FIELD_WIDTH) - cnt6;
  end

  lnce_glyph u_glyph (
    .c                (in_data.in_byte),
    .show_ends        (show_ends_r),
    .show_tabs        (show_tabs_r),
    .show_nonprinting (show_nonprinting_r),
    .glyph            (gly_in)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_index_t'(paddr[4:2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_NUMBER_ALL:       prdata[0] = number_all_r;
      REG_NUMBER_NONBLANK:  prdata[0] = number_nonblank_r;
      REG_SQUEEZE_BLANK:    prdata[0] = squeeze_blank_r;
      REG_SHOW_ENDS:        prdata[0] = show_ends_r;
      REG_SHOW_TABS:        prdata[0] = show_tabs_r;
      REG_SHOW_NONPRINTING: prdata[0] = show_nonprinting_r;
      default:              prdata    = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_all_r       <= 1'b0;
      number_nonblank_r  <= 1'b0;
      squeeze_blank_r    <= 1'b0;
      show_ends_r        <= 1'b0;
      show_tabs_r        <= 1'b0;
      show_nonprinting_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NUMBER_ALL:       number_all_r       <= pwdata[0];
        REG_NUMBER_NONBLANK:  number_nonblank_r  <= pwdata[0];
        REG_SQUEEZE_BLANK:    squeeze_blank_r    <= pwdata[0];
        REG_SHOW_ENDS:        show_ends_r        <= pwdata[0];
        REG_SHOW_TABS:        show_tabs_r        <= pwdata[0];
        REG_SHOW_NONPRINTING: show_nonprinting_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign in_acc    = in_valid && !in_stall;

  assign ctl.rotate = (state_r == S_DIG) && slot_free;
  assign ctl.incr   = (state_r == S_TAB) && slot_free && !full;

  // line classification of the request
  assign als_eff = in_data.new_file || als_r;
  assign ibr_eff = !in_data.new_file && ibr_r;
  assign is_nl   = (in_data.in_byte == CH_NL);
  assign drop    = is_nl && als_eff && squeeze_blank_r && ibr_eff;
  assign num     = is_nl ? (als_eff && number_all_r && !number_nonblank_r)
                         : (als_eff && (number_all_r || number_nonblank_r));

  assign show_digit = lead_r || (top_digit != DIGIT_ZERO) || (k_r == KLAST);

  always_comb begin
    state_nxt = state_r;
    als_nxt   = als_r;
    ibr_nxt   = ibr_r;
    gly_nxt   = gly_r;
    gidx_nxt  = gidx_r;
    pad_nxt   = pad_r;
    k_nxt     = k_r;
    lead_nxt  = lead_r;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = CH_SPACE;
    case (state_r)
      S_IDLE: begin
        if (in_acc && !drop) begin
          gly_nxt = gly_in;
          als_nxt = is_nl;
          ibr_nxt = is_nl && als_eff;
          if (num) begin
            state_nxt = (pad_now != 3'd0) ? S_PAD : S_DIG;
            pad_nxt   = pad_now;
            k_nxt     = '0;
            lead_nxt  = 1'b0;
          end else begin
            emit      = 1'b1;
            emit_byte = gly_in.bytes[0];
            emit_last = (gly_in.cnt == 3'd1);
            if (gly_in.cnt != 3'd1) begin
              state_nxt = S_GLY;
              gidx_nxt  = 2'd1;
            end
          end
        end
      end
      S_PAD: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = CH_SPACE;
          pad_nxt   = pad_r - 3'd1;
          if (pad_r == 3'd1) begin
            state_nxt = S_DIG;
          end
        end
      end
      S_DIG: begin
        // the chain rotates once; skip leading zeros
        if (slot_free) begin
          if (show_digit) begin
            emit      = 1'b1;
            emit_byte = CH_ZERO + {4'b0000, top_digit};
            lead_nxt  = 1'b1;
          end
          k_nxt = k_r + 1'b1;
          if (k_r == KLAST) begin
            state_nxt = S_TAB;
          end
        end
      end
      S_TAB: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = CH_TAB;
          state_nxt = S_GLY;
          gidx_nxt  = 2'd0;
        end
      end
      S_GLY: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_byte = gly_r.bytes[gidx_r];
          emit_last = ({1'b0, gidx_r} + 3'd1 == gly_r.cnt);
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            gidx_nxt = gidx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (slot_free) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_data_nxt.out_byte    = emit_byte;
        out_data_nxt.last_of_run = emit_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      als_r       <= 1'b1;
      ibr_r       <= 1'b0;
      out_valid_r <= 1'b0;
      gidx_r      <= 2'd0;
      pad_r       <= 3'd0;
      k_r         <= '0;
      lead_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      als_r       <= als_nxt;
      ibr_r       <= ibr_nxt;
      out_valid_r <= out_valid_nxt;
      gidx_r      <= gidx_nxt;
      pad_r       <= pad_nxt;
      k_r         <= k_nxt;
      lead_r      <= lead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gly_r      <= gly_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a byte that is not the last of its run is always followed by more work
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last_of_run) |-> (state_r != S_IDLE))
    else $error("non-final output byte with filter idle");

  // the tab cycle advances the counter unless it is saturated
  a_counter_steps: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_TAB) && slot_free && !full) |=> (digits != $past(digits)))
    else $error("line counter did not advance after a number");

  // no request is taken while a run is still being emitted
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("request accepted while filter busy");

endmodule

/* hw/rtl/lnce_cell.sv */
// lnce_cell: one BCD digit of the line counter chain.
// Rotates with its neighbor while the number is shown, increments on carry.
// Depends on lnce_pkg.
module lnce_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lnce_pkg::cell_ctl_t ctl,
  input  logic [3:0]        reset_digit,
  input  logic [3:0]        rot_in,
  input  logic              nines_in,
  input  logic              nz_in,
  output logic [3:0]        digit,
  output logic              nines_out,
  output logic              nz_out
);
  import lnce_pkg::*;

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.rotate) begin
      digit_nxt = rot_in;
    end else if (ctl.incr && nines_in) begin
      digit_nxt = (digit_r == DIGIT_NINE) ? DIGIT_ZERO : digit_r + DIGIT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= reset_digit;
    end else begin
      digit_r <= digit_nxt;
    end
  end

  assign digit     = digit_r;
  // all digits below and this one are nine: carry passes on
  assign nines_out = nines_in && (digit_r == DIGIT_NINE);
  // this digit or one above is significant
  assign nz_out    = nz_in || (digit_r != DIGIT_ZERO);

  a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
    digit_r <= DIGIT_NINE)
    else $error("digit cell left BCD range");

endmodule

/* hw/rtl/lnce_glyph.sv */
// lnce_glyph: renders one input byte as its display bytes (newline, tab,
// caret and M- notation). Combinational. Depends on lnce_pkg.
module lnce_glyph (
  input  logic [7:0]       c,
  input  logic             show_ends,
  input  logic             show_tabs,
  input  logic             show_nonprinting,
  output lnce_pkg::glyph_t glyph
);
  import lnce_pkg::*;

  logic [6:0] lo;
  logic [1:0] pos;

  assign lo  = c[6:0];
  assign pos = c[7] ? 2'd2 : 2'd0;

  always_comb begin
    glyph.bytes = '0;
    glyph.cnt   = 3'd1;
    if (c == CH_NL) begin
      if (show_ends) begin
        glyph.bytes[0] = CH_DOLLAR;
        glyph.bytes[1] = CH_NL;
        glyph.cnt      = 3'd2;
      end else begin
        glyph.bytes[0] = CH_NL;
      end
    end else if (c == CH_TAB) begin
      if (show_tabs) begin
        glyph.bytes[0] = CH_CARET;
        glyph.bytes[1] = CH_I;
        glyph.cnt      = 3'd2;
      end else begin
        glyph.bytes[0] = CH_TAB;
      end
    end else if (!show_nonprinting) begin
      glyph.bytes[0] = c;
    end else begin
      // high bytes: prefix M- and classify the low seven bits
      if (c[7]) begin
        glyph.bytes[0] = CH_M;
        glyph.bytes[1] = CH_DASH;
      end
      if (lo < CTRL_LIMIT) begin
        glyph.bytes[pos]             = CH_CARET;
        glyph.bytes[2'(pos + 2'd1)]  = {1'b0, lo} + CTRL_OFFSET;
        glyph.cnt                    = {1'b0, pos} + 3'd2;
      end else if (lo == CH_DEL) begin
        glyph.bytes[pos]             = CH_CARET;
        glyph.bytes[2'(pos + 2'd1)]  = CH_QMARK;
        glyph.cnt                    = {1'b0, pos} + 3'd2;
      end else begin
        glyph.bytes[pos]             = {1'b0, lo};
        glyph.cnt                    = {1'b0, pos} + 3'd1;
      end
    end
  end

endmodule
